// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clock and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- rtl/i2cbm_pkg.sv -----
package i2cbm_pkg;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned HALF_W     = 16;
   localparam logic [HALF_W-1:0] HALF_RESET = 16'd5;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_ACK     = 3'd3,
      OP_NACK    = 3'd4,
      OP_WAITACK = 3'd5,
      OP_WRITE   = 3'd6,
      OP_READ    = 3'd7
   } op_type;

   // classified transaction as it sits in the queue
   typedef struct packed {
      op_type     op;
      logic       is_cmd;
      logic [7:0] seed;
      logic       sda;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [2:0] phase_count(input op_type c);
      case (c)
         OP_START: phase_count = 3'd2;
         OP_STOP:  phase_count = 3'd2;
         OP_ACK:   phase_count = 3'd5;
         OP_WRITE: phase_count = 3'd4;
         default:  phase_count = 3'd3;
      endcase
   endfunction

   function automatic logic [3:0] bit_count(input op_type c);
      bit_count = (c == OP_WRITE || c == OP_READ) ? BITS_PER_BYTE : 4'd1;
   endfunction

   // pin levels {scl, sda} set at the start of a phase
   function automatic logic [1:0] apply_phase(input op_type c, input logic [2:0] p,
                                              input logic msb, input logic scl,
                                              input logic sda);
      logic s_c;
      logic s_d;
      s_c = scl;
      s_d = sda;
      case (c)
         OP_START: begin
            if (p == 3'd0) begin
               s_c = 1'b1;
               s_d = 1'b1;
            end else begin
               s_d = 1'b0;
            end
         end
         OP_STOP: begin
            if (p == 3'd0) begin
               s_c = 1'b1;
               s_d = 1'b0;
            end else begin
               s_d = 1'b1;
            end
         end
         OP_ACK: begin
            case (p)
               3'd0: begin
                  s_c = 1'b0;
                  s_d = 1'b1;
               end
               3'd1: s_d = 1'b0;
               3'd2: s_c = 1'b1;
               3'd3: s_c = 1'b0;
               default: s_d = 1'b1;
            endcase
         end
         OP_WRITE: begin
            case (p)
               3'd0: begin
                  s_c = 1'b0;
                  s_d = 1'b0;
               end
               3'd1: s_d = msb;
               3'd2: s_c = 1'b1;
               default: s_c = 1'b0;
            endcase
         end
         default: begin
            case (p)
               3'd0: begin
                  s_c = 1'b0;
                  s_d = 1'b1;
               end
               3'd1: s_c = 1'b1;
               default: s_c = 1'b0;
            endcase
         end
      endcase
      apply_phase = {s_c, s_d};
   endfunction

endpackage

// ----- rtl/i2c_bit_level_master.sv -----
// path: an accepted transaction is written into the command queue, then its result
// into the engine's output register, which drives the response port
// throughput: one transaction per cycle, set by the engine step, while the response port is not stalled
// reset: synchronous, active high; queue empties, pins read released high,
// engine idle, half period returns to 5 ticks
`include "assert_macros.svh"

module i2c_bit_level_master
   import i2cbm_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [HALF_W-1:0]     csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,   // operation
   input  logic [REQ_DATA_W-1:0] req_tdata,   // tx_byte[7:0], sda_in[8], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], rejected[4],
   // rx_byte[12:5], nack[13], zeros
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [HALF_W-1:0] half_ff;
   q_status_type      q_status;
   logic              push;
   item_type          push_item;
   logic              q_valid;
   item_type          q_item;
   logic              q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   i2cbm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .item       (push_item)
   );

   i2cbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item),
      .status    (q_status)
   );

   i2cbm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   `ASSERT_NEVER(a_queue_state, q_status.full && q_status.empty, "queue full and empty at once")
   `ASSERT_SAME(a_done_idle, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2], "done while still busy")
   `ASSERT_NEXT(a_drain, rsp_tvalid && rsp_tready && q_status.empty, !rsp_tvalid, "result without transaction")

endmodule

// ----- rtl/i2cbm_front.sv -----
module i2cbm_front
   import i2cbm_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  q_status_type          q_status,
   output logic                  push,
   output item_type              item
);

   op_type op;

   always_comb begin
      op          = op_type'(req_tuser);
      req_tready  = !q_status.full;
      push        = req_tvalid && !q_status.full;
      item.op     = op;
      item.is_cmd = (op != OP_TICK);
      // only a write byte loads the shifter
      item.seed   = (op == OP_WRITE) ? req_tdata[7:0] : 8'd0;
      item.sda    = req_tdata[8];
   end

endmodule

// ----- rtl/i2cbm_queue.sv -----
module i2cbm_queue
   import i2cbm_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_type     push_item,
   input  logic         pop,
   output logic         pop_valid,
   output item_type     pop_item,
   output q_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
      pop_valid    = !status.empty;
      pop_item     = mem_ff[rd_ptr_ff];
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/i2cbm_engine.sv -----
module i2cbm_engine
   import i2cbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [HALF_W-1:0]     half_period,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   op_type              cmd_ff;
   op_type              cmd_in;
   logic [2:0]          phase_ff;
   logic [2:0]          phase_in;
   logic [3:0]          bit_ff;
   logic [3:0]          bit_in;
   logic [HALF_W-1:0]   tick_ff;
   logic [HALF_W-1:0]   tick_in;
   logic [7:0]          shift_ff;
   logic [7:0]          shift_in;
   logic                scl_ff;
   logic                scl_in;
   logic                sda_ff;
   logic                sda_in;
   logic                busy_ff;
   logic                busy_in;
   logic                nack_ff;
   logic                nack_in;
   logic [7:0]          rx_ff;
   logic [7:0]          rx_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [HALF_W-1:0]   limit;
   logic                rej;
   logic                done;
   logic                step;

   assign step       = q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_pop      = step;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      limit    = (half_period == '0) ? HALF_W'(1) : half_period;
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      busy_in  = busy_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      rej      = 1'b0;
      done     = 1'b0;

      if (!busy_in) begin
         if (q_item.is_cmd) begin
            cmd_in   = q_item.op;
            phase_in = 3'd0;
            bit_in   = 4'd0;
            tick_in  = '0;
            shift_in = q_item.seed;
            busy_in  = 1'b1;
            {scl_in, sda_in} = apply_phase(cmd_in, phase_in, shift_in[7], scl_in, sda_in);
         end
      end else if (q_item.is_cmd) begin
         rej = 1'b1;
      end

      // the accepting transaction also counts as the first tick
      if (busy_in) begin
         tick_in = tick_in + HALF_W'(1);
         if (tick_in >= limit) begin
            tick_in = '0;
            if (phase_in == 3'd1 && cmd_in == OP_WAITACK) begin
               nack_in = q_item.sda;
            end
            if (phase_in == 3'd1 && cmd_in == OP_READ) begin
               shift_in = {shift_in[6:0], q_item.sda};
            end
            if (phase_in == 3'd3 && cmd_in == OP_WRITE) begin
               shift_in = {shift_in[6:0], 1'b0};
            end
            phase_in = phase_in + 3'd1;
            if (phase_in >= phase_count(cmd_in)) begin
               phase_in = 3'd0;
               bit_in   = bit_in + 4'd1;
               if (bit_in >= bit_count(cmd_in)) begin
                  if (cmd_in == OP_READ) begin
                     rx_in = shift_in;
                  end
                  bit_in  = 4'd0;
                  busy_in = 1'b0;
                  done    = 1'b1;
               end
            end
            if (busy_in) begin
               {scl_in, sda_in} = apply_phase(cmd_in, phase_in, shift_in[7], scl_in, sda_in);
            end
         end
      end

      rsp_data_in = {2'b00, nack_in, rx_in, rej, done, busy_in, sda_in, scl_in};

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= OP_TICK;
         phase_ff     <= 3'd0;
         bit_ff       <= 4'd0;
         tick_ff      <= '0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         busy_ff      <= 1'b0;
         nack_ff      <= 1'b0;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            busy_ff  <= busy_in;
            nack_ff  <= nack_in;
            rx_ff    <= rx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
